>>> sv/srbt_pkg.sv
// Package for the scanout resource binding table: sizes, codes and the
// request and result payload types. No dependencies.
package srbt_pkg;

  localparam int unsigned ResourceSlots = 16;
  localparam int unsigned OutputCount   = 4;
  localparam int unsigned SlotW = $clog2(ResourceSlots);
  localparam int unsigned OutW  = (OutputCount > 1) ? $clog2(OutputCount) : 1;

  localparam logic [2:0] OP_PUBLISH = 3'd0;
  localparam logic [2:0] OP_DESTROY = 3'd1;
  localparam logic [2:0] OP_ASSIGN  = 3'd2;
  localparam logic [2:0] OP_SURFACE = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_PRESENT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_STALE     = 3'd3;
  localparam logic [2:0] ST_IO        = 3'd4;
  localparam logic [2:0] ST_NO_SPACE  = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] buffer_id;
    logic [31:0] generation;
    logic [7:0]  output_index;
    logic        surface_attach;
    logic        payload_valid;
    logic        import_ok;
    logic [31:0] import_handle;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [31:0] handle;
    logic [7:0]  present_output;
    logic [31:0] surface_gen_out;
    logic [15:0] out_rect_x;
    logic [15:0] out_rect_y;
    logic [15:0] out_rect_width;
    logic [15:0] out_rect_height;
    logic        last;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;     // capture the request
    logic scan_clear;   // restart the slot scan
    logic scan_step;    // inspect one slot and advance
    logic out_clear;    // restart the output walk
    logic out_step;     // inspect one output and advance
    logic write_pub;    // commit a publish
    logic write_del;    // commit a destroy of the found slot
    logic write_asg;    // commit an assign
    logic write_srf;    // commit a set surface
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic found;
    logic free_seen;
    logic out_done;
    logic out_hit;      // the output being walked is bound to the id
    logic out_live;     // and also attached
  } sts_t;

endpackage

>>> sv/srbt_if.sv
// Valid/ready channel carrying one payload of the binding table.
// Depends on srbt_pkg for the payload types.
interface srbt_req_if import srbt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srbt_res_if import srbt_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/srbt_datapath.sv
// Datapath of the binding table: slot and output stores, request register,
// scan and walk counters. Depends on srbt_pkg.
module srbt_datapath import srbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output req_t        req_o,
  output logic [31:0] slot_gen_o,
  output logic [31:0] slot_handle_o,
  output logic [OutW-1:0] out_idx_o,
  output logic [31:0] out_sgen_o,
  output logic [63:0] out_rect_o
);

  logic [ResourceSlots-1:0] occ_q;
  logic [31:0] id_q   [ResourceSlots];
  logic [31:0] gen_q  [ResourceSlots];
  logic [31:0] hdl_q  [ResourceSlots];
  logic [OutputCount-1:0] bound_q, attached_q;
  logic [31:0] obid_q [OutputCount];
  logic [63:0] rect_q [OutputCount];
  logic [31:0] sgen_q [OutputCount];

  req_t req_q;
  logic [SlotW:0] scan_q;
  logic [SlotW-1:0] hit_q, free_q;
  logic found_q, free_seen_q;
  logic [OutW:0] walk_q;

  logic [SlotW-1:0] scan_idx;
  logic [OutW-1:0] walk_idx, oi;
  logic [SlotW-1:0] tgt;

  assign scan_idx = scan_q[SlotW-1:0];
  assign walk_idx = walk_q[OutW-1:0];
  assign oi       = req_q.output_index[OutW-1:0];
  assign tgt      = found_q ? hit_q : free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      bound_q     <= '0;
      attached_q  <= '0;
      scan_q      <= '0;
      walk_q      <= '0;
      hit_q       <= '0;
      free_q      <= '0;
      found_q     <= 1'b0;
      free_seen_q <= 1'b0;
      for (int i = 0; i < ResourceSlots; i++) begin
        id_q[i]  <= '0;
        gen_q[i] <= '0;
        hdl_q[i] <= '0;
      end
      for (int o = 0; o < OutputCount; o++) begin
        obid_q[o] <= '0;
        rect_q[o] <= '0;
        sgen_q[o] <= '0;
      end
    end else begin
      if (cmd_i.scan_clear) begin
        scan_q      <= '0;
        found_q     <= 1'b0;
        free_seen_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (!found_q && occ_q[scan_idx] && id_q[scan_idx] == req_q.buffer_id) begin
          found_q <= 1'b1;
          hit_q   <= scan_idx;
        end
        if (!free_seen_q && !occ_q[scan_idx]) begin
          free_seen_q <= 1'b1;
          free_q      <= scan_idx;
        end
      end
      if (cmd_i.out_clear) begin
        walk_q <= '0;
      end else if (cmd_i.out_step) begin
        walk_q <= walk_q + 1'b1;
        // Destroy unbinds every output holding the id while walking.
        if (req_q.operation == OP_DESTROY && sts_o.out_hit) begin
          bound_q[walk_idx] <= 1'b0;
          obid_q[walk_idx]  <= '0;
          rect_q[walk_idx]  <= '0;
        end
      end
      if (cmd_i.write_pub) begin
        occ_q[tgt] <= 1'b1;
        id_q[tgt]  <= req_q.buffer_id;
        gen_q[tgt] <= req_q.generation;
        hdl_q[tgt] <= req_q.import_handle;
      end
      if (cmd_i.write_del) begin
        occ_q[hit_q] <= 1'b0;
        id_q[hit_q]  <= '0;
        gen_q[hit_q] <= '0;
        hdl_q[hit_q] <= '0;
      end
      if (cmd_i.write_asg) begin
        bound_q[oi] <= (req_q.buffer_id != '0);
        obid_q[oi]  <= req_q.buffer_id;
        rect_q[oi]  <= (req_q.buffer_id != '0) ?
                       {req_q.rect_height, req_q.rect_width, req_q.rect_y, req_q.rect_x} :
                       64'd0;
      end
      if (cmd_i.write_srf) begin
        attached_q[oi] <= req_q.surface_attach;
        sgen_q[oi]     <= req_q.surface_attach ? req_q.generation : 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  assign sts_o.scan_done = scan_q[SlotW];
  assign sts_o.found     = found_q;
  assign sts_o.free_seen = free_seen_q;
  assign sts_o.out_done  = (walk_q == (OutW+1)'(OutputCount));
  assign sts_o.out_hit   = !sts_o.out_done && bound_q[walk_idx] &&
                           obid_q[walk_idx] == req_q.buffer_id;
  assign sts_o.out_live  = sts_o.out_hit && attached_q[walk_idx];

  assign req_o         = req_q;
  assign slot_gen_o    = gen_q[hit_q];
  assign slot_handle_o = hdl_q[hit_q];
  assign out_idx_o     = walk_idx;
  assign out_sgen_o    = sgen_q[walk_idx];
  assign out_rect_o    = rect_q[walk_idx];

endmodule

>>> sv/srbt_ctrl.sv
// Controller of the binding table: sequences each request and forms the
// result transactions. Depends on srbt_pkg.
module srbt_ctrl import srbt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_data_o,
  output cmd_t        cmd_o,
  input  sts_t        sts_i,
  input  req_t        req_i,
  input  logic [31:0] slot_gen_i,
  input  logic [31:0] slot_handle_i,
  input  logic [OutW-1:0] out_idx_i,
  input  logic [31:0] out_sgen_i,
  input  logic [63:0] out_rect_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_DECIDE, S_WALK, S_EMIT, S_FINAL
  } state_e;

  state_e state_q;
  logic   pend_q;   // a result is waiting in the output register
  logic   pend_d;
  res_t   res_q;
  logic [2:0] st_q; // status saved for the closing transaction
  state_e after_q;  // where to go once a release is taken
  logic   wr_pub_q, wr_del_q, wr_asg_q, wr_srf_q;

  logic out_free;
  logic in_range, pub_bad;
  logic accept, present_now;

  assign out_free   = !pend_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign out_valid_o = pend_q;
  assign out_data_o  = res_q;
  assign accept      = in_valid_i && in_ready_o;

  assign in_range = (req_i.output_index < 8'(OutputCount));
  assign pub_bad  = req_i.buffer_id == '0 || req_i.generation == '0 || !req_i.payload_valid;

  assign present_now = (state_q == S_WALK) && out_free && !sts_i.out_done &&
                       req_i.operation == OP_FLUSH && sts_i.out_live;

  function automatic res_t mk(input logic [1:0] k, input logic [2:0] s,
                              input logic [31:0] h);
    res_t r;
    r = '0;
    r.result_kind = k;
    r.status = s;
    r.handle = h;
    r.last = (k == KIND_STATUS);
    return r;
  endfunction

  function automatic res_t mk_present(input logic [31:0] h, input logic [OutW-1:0] idx,
                                      input logic [31:0] sg, input logic [63:0] rect);
    res_t r;
    r = '0;
    r.result_kind     = KIND_PRESENT;
    r.handle          = h;
    r.present_output  = 8'(idx);
    r.surface_gen_out = sg;
    {r.out_rect_height, r.out_rect_width, r.out_rect_y, r.out_rect_x} = rect;
    return r;
  endfunction

  always_comb begin
    cmd_o = '0;
    cmd_o.load_req   = accept;
    cmd_o.scan_clear = accept;
    cmd_o.scan_step  = (state_q == S_SCAN) && !sts_i.scan_done;
    cmd_o.out_clear  = accept;
    cmd_o.out_step   = (state_q == S_WALK) && out_free && !sts_i.out_done;
    cmd_o.write_pub  = wr_pub_q;
    cmd_o.write_del  = wr_del_q;
    cmd_o.write_asg  = wr_asg_q;
    cmd_o.write_srf  = wr_srf_q;
  end

  // The output register fills on a release, a present or the status, and
  // empties when the result side takes it.
  always_comb begin
    pend_d = pend_q && !out_ready_i;
    if (out_free && (state_q == S_EMIT || state_q == S_FINAL)) pend_d = 1'b1;
    if (present_now) pend_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_q   <= 1'b0;
      res_q    <= '0;
      st_q     <= ST_OK;
      after_q  <= S_FINAL;
      wr_pub_q <= 1'b0;
      wr_del_q <= 1'b0;
      wr_asg_q <= 1'b0;
      wr_srf_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      wr_pub_q <= 1'b0;
      wr_del_q <= 1'b0;
      wr_asg_q <= 1'b0;
      wr_srf_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept) state_q <= S_DECODE;
        S_DECODE: begin
          unique case (req_i.operation)
            OP_PUBLISH: begin
              if (pub_bad) begin st_q <= ST_INVALID; state_q <= S_FINAL; end
              else state_q <= S_SCAN;
            end
            OP_DESTROY, OP_FLUSH: begin
              if (req_i.buffer_id == '0 ||
                  (req_i.operation == OP_FLUSH && req_i.generation == '0)) begin
                st_q <= ST_INVALID; state_q <= S_FINAL;
              end else state_q <= S_SCAN;
            end
            OP_ASSIGN: begin
              if (!in_range) begin st_q <= ST_INVALID; state_q <= S_FINAL; end
              else if (req_i.buffer_id == '0) begin
                wr_asg_q <= 1'b1; st_q <= ST_OK; state_q <= S_FINAL;
              end else if (req_i.rect_width == '0 || req_i.rect_height == '0) begin
                st_q <= ST_INVALID; state_q <= S_FINAL;
              end else state_q <= S_SCAN;
            end
            OP_SURFACE: begin
              if (!in_range || (req_i.surface_attach && req_i.generation == '0)) begin
                st_q <= ST_INVALID;
              end else begin
                wr_srf_q <= 1'b1; st_q <= ST_OK;
              end
              state_q <= S_FINAL;
            end
            default: begin st_q <= ST_INVALID; state_q <= S_FINAL; end
          endcase
        end
        S_SCAN: if (sts_i.scan_done) state_q <= S_DECIDE;
        S_DECIDE: begin
          state_q <= S_FINAL;
          after_q <= S_FINAL;
          unique case (req_i.operation)
            OP_PUBLISH: begin
              if (sts_i.found && slot_gen_i >= req_i.generation) begin
                st_q <= (slot_gen_i == req_i.generation) ? ST_ALREADY : ST_STALE;
              end else if (!req_i.import_ok || req_i.import_handle == '0) begin
                st_q <= ST_IO;
                if (req_i.import_handle != '0) begin
                  res_q <= mk(KIND_RELEASE, ST_OK, req_i.import_handle);
                  state_q <= S_EMIT;
                end
              end else if (!sts_i.found && !sts_i.free_seen) begin
                st_q <= ST_NO_SPACE;
                res_q <= mk(KIND_RELEASE, ST_OK, req_i.import_handle);
                state_q <= S_EMIT;
              end else begin
                st_q <= ST_OK;
                wr_pub_q <= 1'b1;
                if (sts_i.found) begin
                  res_q <= mk(KIND_RELEASE, ST_OK, slot_handle_i);
                  state_q <= S_EMIT;
                end
              end
            end
            OP_DESTROY: begin
              if (!sts_i.found) st_q <= ST_NOT_FOUND;
              else begin
                st_q <= ST_OK;
                res_q <= mk(KIND_RELEASE, ST_OK, slot_handle_i);
                after_q <= S_WALK;
                state_q <= S_EMIT;
              end
            end
            OP_ASSIGN: begin
              if (!sts_i.found) st_q <= ST_NOT_FOUND;
              else begin st_q <= ST_OK; wr_asg_q <= 1'b1; end
            end
            default: begin
              if (!sts_i.found) st_q <= ST_NOT_FOUND;
              else if (slot_gen_i != req_i.generation) st_q <= ST_STALE;
              else begin st_q <= ST_OK; state_q <= S_WALK; end
            end
          endcase
        end
        S_EMIT: begin
          if (out_free) state_q <= after_q;
        end
        S_WALK: begin
          if (out_free) begin
            if (sts_i.out_done) begin
              // The release is delivered before the slot is cleared.
              if (req_i.operation == OP_DESTROY) wr_del_q <= 1'b1;
              state_q <= S_FINAL;
            end else if (present_now) begin
              res_q <= mk_present(slot_handle_i, out_idx_i, out_sgen_i, out_rect_i);
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            res_q   <= mk(KIND_STATUS, st_q, 32'd0);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.result_kind == KIND_STATUS)))
    else $error("last flag disagrees with result kind");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("request accepted while busy");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.write_pub, cmd_o.write_del, cmd_o.write_asg, cmd_o.write_srf}) <= 1)
    else $error("two store writes at once");
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && out_free) |=> (state_q == S_IDLE && pend_q))
    else $error("status transaction not issued");
`endif

endmodule

>>> sv/scanout_resource_binding_table_top.sv
// Top level of the scanout resource binding table: joins controller and
// datapath to the request and result channels. Depends on srbt_pkg, srbt_if.

// A request is taken only when the block is idle and its output register is
// free. Each request scans all 16 buffer slots one per cycle where it needs a
// lookup, then walks the 4 outputs for destroy and flush, one per cycle while
// the output register is free; a stall on the result side holds the walk.
// Results come in order: releases, then presents, then one status with last.
module scanout_resource_binding_table_top import srbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  srbt_req_if.sink   req_if,
  srbt_res_if.source res_if
);

  cmd_t cmd;
  sts_t sts;
  req_t req_cur;
  logic [31:0] slot_gen, slot_handle, out_sgen;
  logic [OutW-1:0] out_idx;
  logic [63:0] out_rect;

  srbt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .out_valid_o(res_if.valid),
    .out_ready_i(res_if.ready),
    .out_data_o (res_if.data),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .req_i      (req_cur),
    .slot_gen_i (slot_gen),
    .slot_handle_i(slot_handle),
    .out_idx_i  (out_idx),
    .out_sgen_i (out_sgen),
    .out_rect_i (out_rect)
  );

  srbt_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i        (req_if.data),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_o        (req_cur),
    .slot_gen_o   (slot_gen),
    .slot_handle_o(slot_handle),
    .out_idx_o    (out_idx),
    .out_sgen_o   (out_sgen),
    .out_rect_o   (out_rect)
  );

endmodule
